FILE: sv/frlsm_pkg.sv
// Package for the flash ring log slot manager: widths, opcodes, state and
// item/result types, and the pointer overtake helper.
// No dependencies.
package frlsm_pkg;

    localparam int IDX_W       = 10;
    localparam int CYC_W       = 64;
    localparam int SLOT_COUNT  = 1024;
    localparam int BLOCK_SLOTS = 16;
    localparam int BLK_W       = $clog2(BLOCK_SLOTS);

    localparam logic [IDX_W:0]   SLOT_LIMIT = (IDX_W + 1)'(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LOW_MASK   = IDX_W'(BLOCK_SLOTS - 1);
    localparam logic [IDX_W-1:0] HIGH_MASK  = ~LOW_MASK;
    localparam logic [IDX_W:0]   BLOCK_STEP = (IDX_W + 1)'(BLOCK_SLOTS);
    localparam logic [CYC_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [2:0] {
        OP_SCAN      = 3'd0,
        OP_FINISH    = 3'd1,
        OP_ACQUIRE   = 3'd2,
        OP_SEND_PICK = 3'd3,
        OP_MARK_SENT = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [IDX_W-1:0] record_index;
        logic [CYC_W-1:0] record_cycle;
        logic             record_sent_mark;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0] slot_index;
        logic             slot_valid;
        logic [CYC_W-1:0] next_cycle;
        logic             sent_accepted;
    } result_t;

    typedef struct packed {
        logic             log_nonempty;
        logic [CYC_W-1:0] oldest_cycle;
        logic [CYC_W-1:0] newest_cycle;
        logic [IDX_W-1:0] oldest_slot;
        logic [IDX_W-1:0] newest_slot;
        logic             sent_present;
        logic [CYC_W-1:0] newest_sent_cycle;
        logic [IDX_W-1:0] newest_sent_slot;
        logic             pending_valid;
        logic [IDX_W-1:0] pending_slot;
    } state_t;

    // True when pointer p is passed by the oldest slot moving from prev to now.
    function automatic logic overtaken(input logic [IDX_W-1:0] p,
                                       input logic [IDX_W-1:0] prev,
                                       input logic [IDX_W-1:0] now,
                                       input logic wrapped);
        return (prev == p) || ((prev < p) && (wrapped || (now > p)));
    endfunction

endpackage

FILE: sv/frlsm_step.sv
// Next-state and result logic for one operation of the slot manager.
// Depends on frlsm_pkg.
module frlsm_step (
    input  frlsm_pkg::state_t  cur,
    input  frlsm_pkg::item_t   item,
    output frlsm_pkg::state_t  nxt,
    output frlsm_pkg::result_t res
);
    import frlsm_pkg::*;

    always_comb
    begin
        logic [IDX_W:0]   inc;
        logic [IDX_W-1:0] new_newest;
        logic [IDX_W-1:0] prev_old;
        logic [IDX_W:0]   jump;
        logic [IDX_W-1:0] new_old;
        logic             wrapped;
        logic             scan_ok;

        nxt = cur;
        res = '0;
        inc = '0;
        new_newest = '0;
        prev_old = '0;
        jump = '0;
        new_old = '0;
        wrapped = 1'b0;
        scan_ok = 1'b0;

        case (opcode_t'(item.opcode))
            OP_SCAN:
            begin
                scan_ok = (item.record_cycle != EMPTY_WORD) &&
                          ({1'b0, item.record_index} < SLOT_LIMIT);
                if (scan_ok)
                begin
                    if (cur.log_nonempty)
                    begin
                        if (cur.oldest_cycle > item.record_cycle)
                        begin
                            nxt.oldest_cycle = item.record_cycle;
                            nxt.oldest_slot  = item.record_index;
                        end
                        if (cur.newest_cycle < item.record_cycle)
                        begin
                            nxt.newest_cycle = item.record_cycle;
                            nxt.newest_slot  = item.record_index;
                        end
                    end
                    else
                    begin
                        nxt.log_nonempty = 1'b1;
                        nxt.oldest_cycle = item.record_cycle;
                        nxt.newest_cycle = item.record_cycle;
                        nxt.oldest_slot  = item.record_index;
                        nxt.newest_slot  = item.record_index;
                    end
                    if (item.record_sent_mark)
                    begin
                        if (!cur.sent_present ||
                            (cur.newest_sent_cycle < item.record_cycle))
                        begin
                            nxt.sent_present      = 1'b1;
                            nxt.newest_sent_cycle = item.record_cycle;
                            nxt.newest_sent_slot  = item.record_index;
                        end
                    end
                end
            end
            OP_FINISH:
            begin
                nxt.pending_valid = 1'b0;
                res.next_cycle = cur.log_nonempty ? cur.newest_cycle + 64'd1 : 64'd1;
            end
            OP_ACQUIRE:
            begin
                res.slot_valid = 1'b1;
                if (!cur.log_nonempty)
                begin
                    nxt.log_nonempty     = 1'b1;
                    nxt.oldest_slot      = '0;
                    nxt.newest_slot      = '0;
                    nxt.sent_present     = 1'b0;
                    nxt.newest_sent_slot = '0;
                end
                else
                begin
                    inc = {1'b0, cur.newest_slot} + (IDX_W + 1)'(1);
                    new_newest = (inc >= SLOT_LIMIT) ? '0 : inc[IDX_W-1:0];
                    nxt.newest_slot = new_newest;
                    res.slot_index  = new_newest;
                    // Writer enters the oldest block: push oldest a block ahead.
                    if (((new_newest & LOW_MASK) == '0) &&
                        ((new_newest & HIGH_MASK) == (cur.oldest_slot & HIGH_MASK)))
                    begin
                        prev_old = cur.oldest_slot;
                        jump = {1'b0, cur.oldest_slot & HIGH_MASK} + BLOCK_STEP;
                        wrapped = (jump >= SLOT_LIMIT);
                        new_old = wrapped ? '0 : jump[IDX_W-1:0];
                        nxt.oldest_slot = new_old;
                        if (cur.sent_present &&
                            overtaken(cur.newest_sent_slot, prev_old, new_old, wrapped))
                            nxt.sent_present = 1'b0;
                        if (cur.pending_valid &&
                            overtaken(cur.pending_slot, prev_old, new_old, wrapped))
                            nxt.pending_valid = 1'b0;
                    end
                end
            end
            OP_SEND_PICK:
            begin
                nxt.pending_valid = 1'b0;
                if (cur.sent_present)
                begin
                    if (cur.newest_sent_slot != cur.newest_slot)
                    begin
                        inc = {1'b0, cur.newest_sent_slot} + (IDX_W + 1)'(1);
                        nxt.pending_slot  = (inc >= SLOT_LIMIT) ? '0 : inc[IDX_W-1:0];
                        nxt.pending_valid = 1'b1;
                    end
                end
                else if (cur.log_nonempty)
                begin
                    nxt.pending_slot  = cur.oldest_slot;
                    nxt.pending_valid = 1'b1;
                end
                if (nxt.pending_valid)
                begin
                    res.slot_index = nxt.pending_slot;
                    res.slot_valid = 1'b1;
                end
            end
            OP_MARK_SENT:
            begin
                if (cur.pending_valid)
                begin
                    nxt.newest_sent_slot = cur.pending_slot;
                    nxt.sent_present     = 1'b1;
                    res.sent_accepted    = 1'b1;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

FILE: sv/flash_ring_log_slot_manager.sv
// Top level of the flash ring log slot manager: input register, state,
// result register. Depends on frlsm_pkg and frlsm_step.

// Every command is taken when start is high; busy stays low, so a command may
// be issued in every cycle. Each command, whatever its opcode, yields exactly
// one result through the input register, a single pass of next-state logic
// and the result register: done is high for one cycle with slot_index,
// slot_valid, next_cycle and sent_accepted. There is no way to hold a result
// off: capture it while done is high. Commands act on the state in the order
// they are issued.
module flash_ring_log_slot_manager (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    opcode,
    input  logic [frlsm_pkg::IDX_W-1:0]   record_index,
    input  logic [frlsm_pkg::CYC_W-1:0]   record_cycle,
    input  logic                          record_sent_mark,
    output logic                          done,
    output logic [frlsm_pkg::IDX_W-1:0]   slot_index,
    output logic                          slot_valid,
    output logic [frlsm_pkg::CYC_W-1:0]   next_cycle,
    output logic                          sent_accepted
);
    import frlsm_pkg::*;

    logic    in_valid_reg;
    item_t   item_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    done_reg;

    assign busy = 1'b0;

    frlsm_step u_step (
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
            if (in_valid_reg)
                state_reg <= state_next;
        end
    end

    // Payload registers: capture on each transfer, no reset needed.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_reg <= '{opcode, record_index, record_cycle, record_sent_mark};
        if (in_valid_reg)
            res_reg <= res_next;
    end

    assign done          = done_reg;
    assign slot_index    = res_reg.slot_index;
    assign slot_valid    = res_reg.slot_valid;
    assign next_cycle    = res_reg.next_cycle;
    assign sent_accepted = res_reg.sent_accepted;

endmodule

FILE: sv/frlsm_checker.sv
// Port-level checks for the flash ring log slot manager, bound to the top.
// Depends on frlsm_pkg and flash_ring_log_slot_manager.
module frlsm_assert (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [frlsm_pkg::IDX_W-1:0]   slot_index,
    input logic                          slot_valid,
    input logic [frlsm_pkg::CYC_W-1:0]   next_cycle,
    input logic                          sent_accepted
);
    import frlsm_pkg::*;

    // Every transfer yields one result, after the input and result registers.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result missing after command transfer");

    // No result without a matching earlier command.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> ##1 !done)
        else $error("result without a command");

    // Only finish scan reports a cycle number; it carries no slot or commit.
    a_finish_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (next_cycle != '0)) |-> (!slot_valid && !sent_accepted))
        else $error("cycle number mixed with other results");

    // A commit never comes with a slot.
    a_commit_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (done && sent_accepted) |-> (!slot_valid && (slot_index == '0)))
        else $error("commit reported together with a slot");

endmodule

bind flash_ring_log_slot_manager frlsm_assert u_frlsm_assert (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .slot_index    (slot_index),
    .slot_valid    (slot_valid),
    .next_cycle    (next_cycle),
    .sent_accepted (sent_accepted)
);

FILE: tb/frlsm_checker.sv
// Checker for the flash ring log slot manager: watches command and result
// transfers, predicts each result and compares it field by field.
// Depends on frlsm_pkg.
module frlsm_checker
    import frlsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [2:0]       opcode,
    input  logic [IDX_W-1:0] record_index,
    input  logic [CYC_W-1:0] record_cycle,
    input  logic             record_sent_mark,
    input  logic             done,
    input  logic [IDX_W-1:0] slot_index,
    input  logic             slot_valid,
    input  logic [CYC_W-1:0] next_cycle,
    input  logic             sent_accepted,
    output int               fail_count,
    output int               awaited_count
);

    result_t expected_q[$];

    // Predicted log state.
    logic             log_used;
    logic [CYC_W-1:0] low_cyc;
    logic [CYC_W-1:0] high_cyc;
    logic [IDX_W-1:0] tail_slot;
    logic [IDX_W-1:0] head_slot;
    logic             acked_known;
    logic [CYC_W-1:0] acked_cyc;
    logic [IDX_W-1:0] acked_slot;
    logic             offer_open;
    logic [IDX_W-1:0] offer_slot;

    // A pointer is lost when the tail block jumps from prev to now across it.
    function automatic bit swept_past(input logic [IDX_W-1:0] p,
                                      input logic [IDX_W-1:0] prev,
                                      input logic [IDX_W-1:0] now,
                                      input bit               wrapped);
        if (prev == p)
            return 1'b1;
        return (prev < p) && (wrapped || now > p);
    endfunction

    function automatic int field_bad(input string            name,
                                     input logic [CYC_W-1:0] want,
                                     input logic [CYC_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic predict_result(input item_t cmd, output result_t res);
        logic [IDX_W-1:0] prev_tail;
        logic [IDX_W:0]   jump;
        bit               wrapped;
        res = '0;
        case (cmd.opcode)
            OP_SCAN:
            begin
                // Drop empty slots and indexes past the ring.
                if (cmd.record_cycle != EMPTY_WORD && int'(cmd.record_index) < SLOT_COUNT)
                begin
                    if (!log_used)
                    begin
                        log_used  = 1'b1;
                        low_cyc   = cmd.record_cycle;
                        high_cyc  = cmd.record_cycle;
                        tail_slot = cmd.record_index;
                        head_slot = cmd.record_index;
                    end
                    else
                    begin
                        if (cmd.record_cycle < low_cyc)
                        begin
                            low_cyc   = cmd.record_cycle;
                            tail_slot = cmd.record_index;
                        end
                        if (cmd.record_cycle > high_cyc)
                        begin
                            high_cyc  = cmd.record_cycle;
                            head_slot = cmd.record_index;
                        end
                    end
                    if (cmd.record_sent_mark && (!acked_known || cmd.record_cycle > acked_cyc))
                    begin
                        acked_known = 1'b1;
                        acked_cyc   = cmd.record_cycle;
                        acked_slot  = cmd.record_index;
                    end
                end
            end
            OP_FINISH:
            begin
                offer_open     = 1'b0;
                res.next_cycle = log_used ? high_cyc + 1'b1 : CYC_W'(1);
            end
            OP_ACQUIRE:
            begin
                res.slot_valid = 1'b1;
                if (!log_used)
                begin
                    log_used    = 1'b1;
                    tail_slot   = '0;
                    head_slot   = '0;
                    acked_known = 1'b0;
                    acked_slot  = '0;
                end
                else
                begin
                    if (int'(head_slot) + 1 >= SLOT_COUNT)
                        head_slot = '0;
                    else
                        head_slot = head_slot + 1'b1;
                    // Entering the tail block: erase it, push the tail a block ahead.
                    if (head_slot[BLK_W-1:0] == '0 &&
                        head_slot[IDX_W-1:BLK_W] == tail_slot[IDX_W-1:BLK_W])
                    begin
                        prev_tail = tail_slot;
                        jump      = {1'b0, tail_slot[IDX_W-1:BLK_W], {BLK_W{1'b0}}}
                                    + (IDX_W + 1)'(BLOCK_SLOTS);
                        wrapped   = int'(jump) >= SLOT_COUNT;
                        tail_slot = wrapped ? '0 : jump[IDX_W-1:0];
                        if (acked_known && swept_past(acked_slot, prev_tail, tail_slot, wrapped))
                            acked_known = 1'b0;
                        if (offer_open && swept_past(offer_slot, prev_tail, tail_slot, wrapped))
                            offer_open = 1'b0;
                    end
                end
                res.slot_index = head_slot;
            end
            OP_SEND_PICK:
            begin
                offer_open = 1'b0;
                if (acked_known)
                begin
                    if (acked_slot != head_slot)
                    begin
                        offer_slot = (int'(acked_slot) + 1 >= SLOT_COUNT) ? '0
                                                                          : acked_slot + 1'b1;
                        offer_open = 1'b1;
                    end
                end
                else if (log_used)
                begin
                    offer_slot = tail_slot;
                    offer_open = 1'b1;
                end
                if (offer_open)
                begin
                    res.slot_index = offer_slot;
                    res.slot_valid = 1'b1;
                end
            end
            OP_MARK_SENT:
            begin
                // Commit the offered slot; the offer stays open.
                if (offer_open)
                begin
                    acked_slot        = offer_slot;
                    acked_known       = 1'b1;
                    res.sent_accepted = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t   cmd;
        result_t want;
        result_t seen;
        int      bad;
        if (!rst_n)
        begin
            log_used      = 1'b0;
            low_cyc       = '0;
            high_cyc      = '0;
            tail_slot     = '0;
            head_slot     = '0;
            acked_known   = 1'b0;
            acked_cyc     = '0;
            acked_slot    = '0;
            offer_open    = 1'b0;
            offer_slot    = '0;
            expected_q.delete();
            fail_count    <= 0;
            awaited_count <= 0;
        end
        else
        begin
            bad = 0;
            if (done)
            begin
                seen = {slot_index, slot_valid, next_cycle, sent_accepted};
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0h", $time, seen);
                    bad = 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    bad  = field_bad("slot_index", CYC_W'(want.slot_index),
                                     CYC_W'(seen.slot_index))
                         + field_bad("slot_valid", CYC_W'(want.slot_valid),
                                     CYC_W'(seen.slot_valid))
                         + field_bad("next_cycle", want.next_cycle, seen.next_cycle)
                         + field_bad("sent_accepted", CYC_W'(want.sent_accepted),
                                     CYC_W'(seen.sent_accepted));
                end
            end
            if (start && !busy)
            begin
                cmd = {opcode, record_index, record_cycle, record_sent_mark};
                predict_result(cmd, want);
                expected_q.push_back(want);
            end
            fail_count    <= fail_count + bad;
            awaited_count <= expected_q.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// Top of the slot manager testbench: clock, reset, command stimulus and the
// verdict. Depends on frlsm_pkg, flash_ring_log_slot_manager, frlsm_checker.
module tb_top;
    import frlsm_pkg::*;

    localparam int ITEM_TARGET  = 1250;
    localparam int CALM_AFTER   = 1100;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int OP_UNDEF_LO  = 5;
    localparam int OP_UNDEF_HI  = 7;
    localparam logic [CYC_W-1:0] MARK_STEP = 64'h0000_0000_0100_0000;
    localparam logic [CYC_W-1:0] TIE_CYCLE = 64'h8000_0000_0000_0000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [2:0]       opcode;
    logic [IDX_W-1:0] record_index;
    logic [CYC_W-1:0] record_cycle;
    logic             record_sent_mark;
    logic             done;
    logic [IDX_W-1:0] slot_index;
    logic             slot_valid;
    logic [CYC_W-1:0] next_cycle;
    logic             sent_accepted;

    int               fail_count;
    int               awaited_count;
    int               quiet_cycles;
    int               items_sent;
    bit               idle_on;
    bit               paused;
    logic [CYC_W-1:0] low_mark;
    logic [CYC_W-1:0] high_mark;

    flash_ring_log_slot_manager DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .record_index     (record_index),
        .record_cycle     (record_cycle),
        .record_sent_mark (record_sent_mark),
        .done             (done),
        .slot_index       (slot_index),
        .slot_valid       (slot_valid),
        .next_cycle       (next_cycle),
        .sent_accepted    (sent_accepted)
    );

    frlsm_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .record_index     (record_index),
        .record_cycle     (record_cycle),
        .record_sent_mark (record_sent_mark),
        .done             (done),
        .slot_index       (slot_index),
        .slot_valid       (slot_valid),
        .next_cycle       (next_cycle),
        .sent_accepted    (sent_accepted),
        .fail_count       (fail_count),
        .awaited_count    (awaited_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort when neither a command nor a result moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Cycle numbers strictly between the scan extremes of the ring sessions.
    function automatic logic [CYC_W-1:0] mid_cycle();
        logic [CYC_W-1:0] r;
        r        = {$urandom, $urandom};
        r[63:62] = 2'($urandom_range(1, 2));
        return r;
    endfunction

    task automatic issue(input logic [2:0]       op,
                         input logic [IDX_W-1:0] idx,
                         input logic [CYC_W-1:0] cyc,
                         input logic             mark);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 10))
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start            <= 1'b1;
        opcode           <= op;
        record_index     <= idx;
        record_cycle     <= cyc;
        record_sent_mark <= mark;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    // Operations without payload still get random payload bits.
    task automatic command(input logic [2:0] op);
        issue(op, IDX_W'($urandom), {$urandom, $urandom}, 1'($urandom));
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_count != 0)
            @(posedge clk);
    endtask

    // Scan a ring whose oldest record sits a gap of 1 to 1000 slots after its newest one.
    task automatic fill_ring();
        int               gap;
        int               extra;
        logic [IDX_W-1:0] tail;
        tail      = IDX_W'($urandom);
        gap       = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 1000)
                                                : $urandom_range(1, 40);
        low_mark  = low_mark - MARK_STEP;
        high_mark = high_mark + MARK_STEP;
        extra     = $urandom_range(0, 4);
        repeat (extra)
            issue(OP_SCAN, IDX_W'($urandom), mid_cycle(), 1'($urandom));
        issue(OP_SCAN, tail, low_mark, 1'($urandom));
        issue(OP_SCAN, tail - IDX_W'(gap), high_mark, 1'($urandom));
        command(OP_FINISH);
    endtask

    task automatic work_ring(input int ops);
        int r;
        repeat (ops)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                command(OP_ACQUIRE);
            else if (r < 70)
                command(OP_SEND_PICK);
            else if (r < 90)
                command(OP_MARK_SENT);
            else if (r < 94)
                command(OP_FINISH);
            else if (r < 97)
                issue(OP_SCAN, IDX_W'($urandom),
                      ($urandom_range(0, 1) == 0) ? EMPTY_WORD : mid_cycle(), 1'($urandom));
            else
                command(3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)));
        end
    endtask

    initial
    begin
        int u;
        rst_n            = 1'b0;
        start            = 1'b0;
        opcode           = OP_SCAN;
        record_index     = '0;
        record_cycle     = '0;
        record_sent_mark = 1'b0;
        items_sent       = 0;
        idle_on          = 1'b0;
        paused           = 1'b0;
        low_mark         = 64'h3FFF_FFFF_FFFF_FFFF;
        high_mark        = 64'hC000_0000_0000_0000;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty log: nothing pending, nothing to send, first acquisition.
        issue(OP_MARK_SENT, '1, EMPTY_WORD, 1'b1);
        command(OP_SEND_PICK);
        command(OP_FINISH);
        for (u = OP_UNDEF_LO; u <= OP_UNDEF_HI; u++)
            issue(3'(u), '1, EMPTY_WORD, 1'b1);
        command(OP_ACQUIRE);
        command(OP_SEND_PICK);
        command(OP_MARK_SENT);
        // Empty record, then ties: the first scanned slot must hold.
        issue(OP_SCAN, '1, EMPTY_WORD, 1'b1);
        issue(OP_SCAN, '1, TIE_CYCLE, 1'b0);
        issue(OP_SCAN, IDX_W'(512), TIE_CYCLE, 1'b1);
        issue(OP_SCAN, '0, TIE_CYCLE, 1'b1);
        command(OP_FINISH);
        command(OP_MARK_SENT);
        command(OP_SEND_PICK);
        command(OP_MARK_SENT);

        while (items_sent < ITEM_TARGET)
        begin
            idle_on = (items_sent < CALM_AFTER) && ($urandom_range(0, 2) != 0);
            if (!paused && items_sent >= ITEM_TARGET / 2)
            begin
                hold_until_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 7)
                fill_ring();
            work_ring($urandom_range(20, 80));
        end

        // Extreme cycle numbers lock the scan extremes, so they come last.
        idle_on = 1'b0;
        issue(OP_SCAN, IDX_W'(1008), '0, 1'b1);
        issue(OP_SCAN, IDX_W'(1007), EMPTY_WORD - 1'b1, 1'b0);
        issue(OP_SCAN, IDX_W'(3), '0, 1'b0);
        issue(OP_SCAN, IDX_W'(9), EMPTY_WORD - 1'b1, 1'b1);
        command(OP_FINISH);
        command(OP_ACQUIRE);
        command(OP_SEND_PICK);
        command(OP_MARK_SENT);
        command(OP_ACQUIRE);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
sv/frlsm_pkg.sv
sv/frlsm_step.sv
sv/flash_ring_log_slot_manager.sv
sv/frlsm_checker.sv
tb/frlsm_checker.sv
tb/tb_top.sv
